// ----- hdl/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg: shared types and constants of the LED pattern sequencer
// Sizes, request codes and the beat structs used by every module.
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int CHANNELS    = 16;
    localparam int SLOT_MAX    = 15;
    localparam int TABLE_DEPTH = 64;
    localparam int LEVELS      = 16;

    localparam int CH_W   = $clog2(CHANNELS);
    localparam int POS_W  = $clog2(TABLE_DEPTH);
    localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = 4;
    localparam int ADDR_W = CH_W + POS_W;

    localparam logic [2:0] FUNC_STEP    = 3'd0;
    localparam logic [2:0] FUNC_PWM     = 3'd1;
    localparam logic [2:0] FUNC_WR_PAT  = 3'd2;
    localparam logic [2:0] FUNC_WR_DUTY = 3'd3;
    localparam logic [2:0] FUNC_SET_LEN = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  channel;
        logic [5:0]  index;
        logic [15:0] value;
    } req_t;

    typedef struct packed {
        logic [15:0] led_bits;
        logic [3:0]  slot;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ----- hdl/lps_pattern_ram.sv -----
// ----------------------------------------------------------------------------
// lps_pattern_ram: pattern word store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lps_pattern_ram
    import lps_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    mreq,
    output logic [15:0] rdata
);

    logic [15:0] mem_reg [CHANNELS*TABLE_DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem_reg[mreq.waddr] <= mreq.wdata;
        end
        rdata_reg <= mem_reg[mreq.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/lps_seq.sv -----
// ----------------------------------------------------------------------------
// lps_seq: channel sequencer
// Walks the channels one per cycle, save for pair reloads, through a shared
// hold/reload unit; gathers the PWM bit word; holds channel state, duty rows.
// ----------------------------------------------------------------------------
module lps_seq
    import lps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output mem_req_t    mreq,
    input  logic [15:0] rdata,
    output logic        res_valid,
    input  logic        res_ready,
    output rsp_t        res
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_LVL  = 6'b000100,
        S_TGT  = 6'b001000,
        S_PWM  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    state_t             state_reg, state_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic               single_reg, single_next;
    logic [LVL_W-1:0]   lvl_tmp_reg, lvl_tmp_next;
    logic [15:0]        bits_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic [LEN_W-1:0]   len_reg [CHANNELS];
    logic [POS_W-1:0]   pos_reg [CHANNELS];
    logic [LVL_W-1:0]   lvl_reg [CHANNELS];
    logic [15:0]        tgt_reg [CHANNELS];
    logic [15:0]        cnt_reg [CHANNELS];
    logic [15:0]        duty_reg [LEVELS];

    logic               accept;
    logic [16:0]        cnt_inc;
    logic               need_load;
    logic [LEN_W-1:0]   pos1, pos2;
    logic [LVL_W-1:0]   lvl_sat;
    logic [LEN_W-1:0]   new_len;
    logic               pwm_bit;
    logic               last_ch;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign last_ch   = single_reg || (ch_reg == CH_LAST);

    assign cnt_inc   = {1'b0, cnt_reg[ch_reg]} + 17'd1;
    assign need_load = cnt_inc >= {1'b0, tgt_reg[ch_reg]};
    assign pos1      = {1'b0, pos_reg[ch_reg]} + LEN_W'(1);
    assign pos2      = {1'b0, pos_reg[ch_reg]} + LEN_W'(2);
    assign lvl_sat   = (rdata >= 16'(LEVELS)) ? LVL_W'(LEVELS - 1) : rdata[LVL_W-1:0];
    assign new_len   = (req.value[0] || (req.value > 16'(TABLE_DEPTH))) ?
                       '0 : req.value[LEN_W-1:0];
    assign pwm_bit   = duty_reg[lvl_reg[ch_reg]][slot_reg];

    assign res_valid    = (state_reg == S_OUT);
    assign res.led_bits = bits_reg;
    assign res.slot     = slot_reg;

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        single_next  = single_reg;
        lvl_tmp_next = lvl_tmp_reg;
        mreq.we      = 1'b0;
        mreq.waddr   = {req.channel[CH_W-1:0], req.index[POS_W-1:0]};
        mreq.wdata   = req.value;
        mreq.raddr   = {ch_reg, pos_reg[ch_reg]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_STEP:
                        begin
                            ch_next     = '0;
                            single_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        FUNC_PWM:
                        begin
                            ch_next    = '0;
                            state_next = S_PWM;
                        end
                        FUNC_WR_PAT:
                        begin
                            mreq.we = 1'b1;
                        end
                        FUNC_SET_LEN:
                        begin
                            ch_next     = req.channel[CH_W-1:0];
                            single_next = 1'b1;
                            mreq.raddr  = {req.channel[CH_W-1:0], {POS_W{1'b0}}};
                            state_next  = S_LVL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (need_load)
                begin
                    state_next = S_LVL;
                end
                else if (last_ch)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            S_LVL:
            begin
                lvl_tmp_next = lvl_sat;
                mreq.raddr   = {ch_reg, pos1[POS_W-1:0]};
                if (pos1 > len_reg[ch_reg])
                begin
                    if (last_ch)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CH_W'(1);
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_TGT;
                end
            end
            S_TGT:
            begin
                if (last_ch)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_PWM:
            begin
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    ch_next = ch_reg + CH_W'(1);
                end
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ch_reg      <= '0;
            single_reg  <= 1'b0;
            slot_reg    <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
                lvl_reg[i] <= '0;
                tgt_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            for (int j = 0; j < LEVELS; j++)
            begin
                duty_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            single_reg <= single_next;
            if (accept && (req.func == FUNC_WR_DUTY) && (req.index < 6'(LEVELS)))
            begin
                duty_reg[req.index[LVL_W-1:0]] <= req.value;
            end
            if (accept && (req.func == FUNC_SET_LEN))
            begin
                len_reg[req.channel[CH_W-1:0]] <= new_len;
                pos_reg[req.channel[CH_W-1:0]] <= '0;
            end
            if ((state_reg == S_SCAN) && !need_load)
            begin
                cnt_reg[ch_reg] <= cnt_inc[15:0];
            end
            if ((state_reg == S_LVL) && (pos1 > len_reg[ch_reg]))
            begin
                pos_reg[ch_reg] <= '0;
                lvl_reg[ch_reg] <= '0;
                tgt_reg[ch_reg] <= '0;
                cnt_reg[ch_reg] <= '0;
            end
            if (state_reg == S_TGT)
            begin
                lvl_reg[ch_reg] <= lvl_tmp_reg;
                tgt_reg[ch_reg] <= rdata;
                cnt_reg[ch_reg] <= '0;
                pos_reg[ch_reg] <= (pos2 >= len_reg[ch_reg]) ? '0 : pos2[POS_W-1:0];
            end
            if ((state_reg == S_OUT) && res_ready)
            begin
                slot_reg <= (slot_reg >= SLOT_W'(SLOT_MAX)) ? '0 : slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_tmp_reg <= lvl_tmp_next;
        if (accept && (req.func == FUNC_PWM))
        begin
            bits_reg <= '0;
        end
        else if (state_reg == S_PWM)
        begin
            bits_reg[ch_reg] <= pwm_bit;
        end
    end

endmodule

// ----- hdl/led_pattern_sequencer_pwm_top.sv -----
// ----------------------------------------------------------------------------
// led_pattern_sequencer_pwm_top: LED pattern sequencer with PWM output
// Through the single channel update unit and pattern RAM port, a step tick
// walks S_SCAN over every channel, adding S_LVL and, if in range, S_TGT for each
// channel that loads a new pair; a PWM slot walks S_PWM, then holds S_OUT;
// writes stay in S_IDLE and a length set runs S_LVL and, if in range, S_TGT.
// Reset clears all channel state, duty rows and the slot; no clearing pass.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_pwm_top
    import lps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    mem_req_t    mreq;
    logic [15:0] rdata;
    logic        res_valid;
    logic        res_ready;
    rsp_t        res;
    logic        out_valid_reg;
    rsp_t        out_reg;

    lps_pattern_ram u_ram (
        .clk   (clk),
        .mreq  (mreq),
        .rdata (rdata)
    );

    lps_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .mreq      (mreq),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ----- hdl/lps_checker.sv -----
// ----------------------------------------------------------------------------
// lps_checker: port-level checks of the LED pattern sequencer
// Watches the beats on both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lps_checker
    import lps_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic              seen_reg;
    logic [SLOT_W-1:0] last_slot_reg;
    logic [2:0]        pend_reg;
    logic              req_acc;
    logic              rsp_acc;
    logic              pwm_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;
    assign pwm_acc = req_acc && (req.func == FUNC_PWM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_slot_reg <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (rsp_acc)
            begin
                seen_reg      <= 1'b1;
                last_slot_reg <= rsp.slot;
            end
            pend_reg <= pend_reg + 3'(pwm_acc) - 3'(rsp_acc);
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> (seen_reg ? (rsp.slot == last_slot_reg + SLOT_W'(1)) : (rsp.slot == '0)))
        else $error("result slot out of order");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 3'd0)
        else $error("result beat without a pwm slot request");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && ((req.func == FUNC_STEP) || (req.func == FUNC_PWM)) |=> !req_ready)
        else $error("ready right after a multi-cycle request");

endmodule

bind led_pattern_sequencer_pwm_top lps_checker u_lps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the LED pattern sequencer with PWM
// The pattern words that the table lengths used here can reach are written
// first. A short table of directed beats follows, then random beats in phases
// with different idle and stall rates. A behavioral copy of the sequencer
// predicts the PWM result beats that the directed table does not fix; each
// result beat is compared field by field with the block's output.
// ----------------------------------------------------------------------------
module tb_top;
    import lps_pkg::*;

    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES    = 9;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 80;
    localparam int MAX_PRINTS      = 40;
    localparam int SHORT_WORDS     = 8;
    localparam int LONG_CH         = CHANNELS - 1;

    typedef struct {
        req_t beat;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_ready = 1'b0;
    req_t req       = '0;
    logic req_ready;
    logic rsp_valid;
    rsp_t rsp;

    logic [15:0]       pat_mem    [CHANNELS*TABLE_DEPTH];
    logic [15:0]       duty_mem   [LEVELS];
    logic [LEN_W-1:0]  seq_len    [CHANNELS];
    logic [POS_W-1:0]  seq_pos    [CHANNELS];
    logic [LVL_W-1:0]  seq_level  [CHANNELS];
    logic [15:0]       seq_target [CHANNELS];
    logic [15:0]       seq_count  [CHANNELS];
    logic [SLOT_W-1:0] slot_ctr;

    rsp_t     slot_expect_q[$];
    dir_row_t dir_rows[$];
    rsp_t     oldest_want;

    int fail_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    always #5 clk = ~clk;

    led_pattern_sequencer_pwm_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    task automatic report_mismatch(string msg);
        if (fail_count < MAX_PRINTS)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic void clear_model();
        for (int c = 0; c < CHANNELS; c++)
        begin
            seq_len[c]    = '0;
            seq_pos[c]    = '0;
            seq_level[c]  = '0;
            seq_target[c] = '0;
            seq_count[c]  = '0;
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            duty_mem[l] = '0;
        end
        slot_ctr = '0;
    endfunction

    function automatic void load_pair(int c);
        int          p;
        logic [15:0] w;
        p = seq_pos[c];
        w = pat_mem[c*TABLE_DEPTH + p];
        seq_level[c] = (w >= LEVELS) ? LVL_W'(LEVELS - 1) : w[LVL_W-1:0];
        p++;
        if (p > seq_len[c])
        begin
            seq_pos[c]    = '0;
            seq_level[c]  = '0;
            seq_target[c] = '0;
            seq_count[c]  = '0;
            return;
        end
        seq_target[c] = (p < TABLE_DEPTH) ? pat_mem[c*TABLE_DEPTH + p] : 16'h0000;
        seq_count[c]  = '0;
        p++;
        if (p >= seq_len[c])
        begin
            p = 0;
        end
        seq_pos[c] = POS_W'(p);
    endfunction

    function automatic bit apply_beat(req_t r, output rsp_t out);
        logic [15:0] bits;
        int          v;
        out  = '0;
        bits = '0;
        case (r.func)
            FUNC_STEP:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    seq_count[c]++;
                    if (seq_count[c] >= seq_target[c])
                    begin
                        load_pair(c);
                    end
                end
            end
            FUNC_PWM:
            begin
                for (int c = 0; c < CHANNELS && c < 16; c++)
                begin
                    if (duty_mem[seq_level[c]][slot_ctr])
                    begin
                        bits[c] = 1'b1;
                    end
                end
                out.led_bits = bits;
                out.slot     = slot_ctr;
                slot_ctr = (slot_ctr == SLOT_MAX) ? '0 : slot_ctr + SLOT_W'(1);
                return 1'b1;
            end
            FUNC_WR_PAT:
            begin
                pat_mem[r.channel*TABLE_DEPTH + r.index] = r.value;
            end
            FUNC_WR_DUTY:
            begin
                if (r.index < LEVELS)
                begin
                    duty_mem[r.index[LVL_W-1:0]] = r.value;
                end
            end
            FUNC_SET_LEN:
            begin
                v = r.value;
                if (v[0] || v > TABLE_DEPTH)
                begin
                    v = 0;
                end
                seq_len[r.channel] = LEN_W'(v);
                seq_pos[r.channel] = '0;
                load_pair(r.channel);
            end
            default:
            begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void add_row(logic [2:0] f, int ch, int idx, int val,
                                    bit typed = 1'b0, int bits = 0, int sl = 0);
        dir_row_t row;
        row.beat.func     = f;
        row.beat.channel  = 4'(ch);
        row.beat.index    = 6'(idx);
        row.beat.value    = 16'(val);
        row.typed         = typed;
        row.want.led_bits = 16'(bits);
        row.want.slot     = SLOT_W'(sl);
        dir_rows.push_back(row);
    endfunction

    function automatic req_t rand_beat(output bit counted);
        req_t r;
        int   pick;
        r.func    = FUNC_STEP;
        r.channel = 4'($urandom);
        r.index   = 6'($urandom);
        r.value   = 16'($urandom);
        counted   = 1'b1;
        pick      = $urandom_range(0, 99);
        if (pick < 25)
        begin
            r.func = FUNC_STEP;
        end
        else if (pick < 55)
        begin
            r.func = FUNC_PWM;
        end
        else if (pick < 75)
        begin
            r.func = FUNC_WR_PAT;
            if (!r.index[0])
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    r.value = 16'($urandom_range(0, LEVELS + 3));
                end
            end
            else if ($urandom_range(0, 99) < 90)
            begin
                r.value = 16'($urandom_range(0, 3));
            end
            else
            begin
                r.value = 16'($urandom_range(4, 30));
            end
        end
        else if (pick < 85)
        begin
            r.func = FUNC_WR_DUTY;
            if ($urandom_range(0, 99) < 80)
            begin
                r.index = 6'($urandom_range(0, LEVELS - 1));
            end
            counted = (r.index < LEVELS);
        end
        else if (pick < 95)
        begin
            r.func = FUNC_SET_LEN;
            pick   = $urandom_range(0, 99);
            if (pick < 60)
            begin
                r.value = 16'(2 * $urandom_range(1, SHORT_WORDS / 2));
            end
            else if (pick < 70)
            begin
                r.channel = 4'(LONG_CH);
                r.value   = 16'(TABLE_DEPTH);
            end
            else if (pick < 80)
            begin
                r.value = '0;
            end
            else
            begin
                r.value = 16'($urandom_range(TABLE_DEPTH + 1, 16'hFFFF));
            end
        end
        else
        begin
            r.func  = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            counted = 1'b0;
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(req_t r, bit typed, rsp_t typed_rsp);
        rsp_t pred;
        bit   has_rsp;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        has_rsp = apply_beat(r, pred);
        if (typed)
        begin
            slot_expect_q.push_back(typed_rsp);
        end
        else if (has_rsp)
        begin
            slot_expect_q.push_back(pred);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (slot_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (slot_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing expected: bits %h slot %0d",
                                          rsp.led_bits, rsp.slot));
            end
            else
            begin
                oldest_want = slot_expect_q.pop_front();
                if (rsp.led_bits !== oldest_want.led_bits)
                begin
                    report_mismatch($sformatf("led_bits %h, expected %h",
                                              rsp.led_bits, oldest_want.led_bits));
                end
                if (rsp.slot !== oldest_want.slot)
                begin
                    report_mismatch($sformatf("slot %0d, expected %0d",
                                              rsp.slot, oldest_want.slot));
                end
            end
        end
        if (hold_served != hold_asked)
        begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_asked;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        req_t r;
        int   done;
        bit   counted;
        int   words;

        clear_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Only the last channel ever gets a full-depth table; the others stay short.
        for (int c = 0; c < CHANNELS; c++)
        begin
            words = (c == LONG_CH) ? TABLE_DEPTH : SHORT_WORDS;
            for (int i = 0; i < words; i++)
            begin
                r.func    = FUNC_WR_PAT;
                r.channel = 4'(c);
                r.index   = 6'(i);
                r.value   = (i % 2 == 0) ? 16'($urandom_range(0, LEVELS + 3))
                                         : 16'($urandom_range(0, 3));
                send_beat(r, 1'b0, '0);
            end
        end

        add_row(FUNC_PWM,     0,  0,  0,       1'b1, 16'h0000, 0);
        add_row(FUNC_WR_DUTY, 0,  0,  16'hFFFF);
        add_row(FUNC_PWM,     15, 63, 16'hFFFF, 1'b1, 16'hFFFF, 1);
        add_row(FUNC_WR_DUTY, 0,  16, 0);
        add_row(FUNC_PWM,     0,  0,  0,       1'b1, 16'hFFFF, 2);
        add_row(FUNC_WR_DUTY, 0,  63, 0);
        add_row(FUNC_WR_DUTY, 0,  15, 16'h5555);
        add_row(FUNC_WR_PAT,  0,  0,  16'hFFFF);
        add_row(FUNC_WR_PAT,  0,  1,  0);
        add_row(FUNC_WR_PAT,  15, 63, 16'hFFFF);
        add_row(FUNC_SET_LEN, 0,  0,  2);
        add_row(FUNC_PWM,     0,  0,  0);
        add_row(FUNC_SET_LEN, 1,  0,  3);
        add_row(FUNC_SET_LEN, 2,  0,  66);
        add_row(FUNC_SET_LEN, 15, 0,  TABLE_DEPTH);
        add_row(FUNC_SET_LEN, 3,  0,  16'hFFFF);
        add_row(FUNC_STEP,    0,  0,  0);
        add_row(FUNC_PWM,     0,  0,  0);
        add_row(FUNC_SPARE_LO, 15, 63, 16'hFFFF);
        add_row(FUNC_SPARE_HI, 0,  0,  0);
        add_row(FUNC_STEP,    15, 63, 16'hFFFF);
        add_row(FUNC_WR_DUTY, 0,  15, 0);
        add_row(FUNC_PWM,     0,  0,  0);
        add_row(FUNC_SET_LEN, 0,  0,  0);
        add_row(FUNC_PWM,     0,  0,  0);

        foreach (dir_rows[k])
        begin
            send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 51; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            if (ph == 2)
            begin
                hold_asked++;
            end
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                r = rand_beat(counted);
                send_beat(r, 1'b0, '0);
                if (counted)
                begin
                    done++;
                end
            end
            drain_results();
        end

        if (slot_expect_q.size() != 0)
        begin
            report_mismatch("expected result beats left over at the end");
        end
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
